/* src/xy_color_fade_engine_assert.svh */
// Assertion macros shared by the color fade engine checkers.
`ifndef XY_COLOR_FADE_ENGINE_ASSERT_SVH
`define XY_COLOR_FADE_ENGINE_ASSERT_SVH

// Same-cycle implication, off during reset.
`define XYCF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("color fade engine check failed");

// Next-cycle implication, off during reset.
`define XYCF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("color fade engine check failed");

// Next-cycle implication that also holds across reset.
`define XYCF_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("color fade engine reset check failed");

`endif

/* src/xycf_pkg.sv */
// Shared types and constants for the x,y color fade engine.
package xycf_pkg;

  localparam int COORD_BITS   = 16;
  localparam int ELAPSED_BITS = 16;
  localparam int TIME_BITS    = 27;
  localparam int PROD_BITS    = ELAPSED_BITS + COORD_BITS;
  localparam int DIV_CNT_BITS = $clog2(PROD_BITS);
  localparam int REG_IDX_BITS = 2;

  localparam logic [TIME_BITS-1:0] FADE_TIME_MIN = TIME_BITS'(100);

  typedef logic [COORD_BITS-1:0]   coord_t;
  typedef logic [ELAPSED_BITS-1:0] elapsed_t;
  typedef logic [TIME_BITS-1:0]    fade_ms_t;
  typedef logic [PROD_BITS-1:0]    prod_t;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_PRESENT = 2'd1,
    OP_COMMAND = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_FADE  = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_OTHER = 2'd3
  } cmd_kind_t;

  localparam logic [REG_IDX_BITS-1:0] REG_FADE_ON_WRITE     = 2'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_DEFAULT_FADE_TIME = 2'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_WRITE_ENABLE      = 2'd2;

  typedef struct packed {
    logic load_item;
    logic prep;
    logic div_start;
    logic commit_simple;
    logic commit_interp;
    logic load_result;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_busy;
  } dp_status_t;

endpackage

/* src/xycf_item_if.sv */
// Input item channel: valid/ready plus the item fields.
interface xycf_item_if import xycf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           op;
  logic [ELAPSED_BITS-1:0] elapsed_ms;
  logic [COORD_BITS-1:0] color_x;
  logic [COORD_BITS-1:0] color_y;
  logic [1:0]           command_kind;
  logic [TIME_BITS-1:0] command_fade_time;

  modport source (output valid, op, elapsed_ms, color_x, color_y, command_kind,
                  command_fade_time, input ready);
  modport sink (input valid, op, elapsed_ms, color_x, color_y, command_kind,
                command_fade_time, output ready);
endinterface

/* src/xycf_result_if.sv */
// Result channel: valid/ready plus the reported color state.
interface xycf_result_if import xycf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] tracking_x;
  logic [COORD_BITS-1:0] tracking_y;
  logic [COORD_BITS-1:0] present_x;
  logic [COORD_BITS-1:0] present_y;
  logic                  fade_active;
  logic                  write_denied;

  modport source (output valid, tracking_x, tracking_y, present_x, present_y,
                  fade_active, write_denied, input ready);
  modport sink (input valid, tracking_x, tracking_y, present_x, present_y,
                fade_active, write_denied, output ready);
endinterface

/* src/xycf_div.sv */
// Restoring divider, one quotient bit per cycle.
module xycf_div import xycf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  prod_t    dividend,
  input  fade_ms_t divisor,
  output logic     busy,
  output coord_t   quotient
);

  logic [TIME_BITS-1:0]    rem;
  prod_t                   quo;
  fade_ms_t                dvs;
  logic [DIV_CNT_BITS-1:0] cnt;
  logic [TIME_BITS:0]      trial;
  logic                    fits;

  assign trial = {rem, quo[PROD_BITS-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == DIV_CNT_BITS'(PROD_BITS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? TIME_BITS'(trial - {1'b0, dvs}) : trial[TIME_BITS-1:0];
      quo <= {quo[PROD_BITS-2:0], fits};
    end
  end

  // quotient is below the distance, so the low bits carry all of it
  assign quotient = quo[COORD_BITS-1:0];

endmodule

/* src/xycf_datapath.sv */
// Color state, config registers, interpolation lanes and result register.
module xycf_datapath import xycf_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [REG_IDX_BITS-1:0] cfg_index,
  input  logic [TIME_BITS-1:0]    cfg_data,
  input  ctrl_cmd_t               cmd,
  output dp_status_t              status,
  input  logic [1:0]              op,
  input  elapsed_t                elapsed_ms,
  input  coord_t                  color_x,
  input  coord_t                  color_y,
  input  logic [1:0]              command_kind,
  input  fade_ms_t                command_fade_time,
  output coord_t                  res_tracking_x,
  output coord_t                  res_tracking_y,
  output coord_t                  res_present_x,
  output coord_t                  res_present_y,
  output logic                    res_fade_active,
  output logic                    res_write_denied
);

  // config
  logic     fade_on_write;
  fade_ms_t dflt_fade_ms;
  logic     write_enable;

  // latched item
  logic [1:0] op_q;
  elapsed_t   ms_q;
  coord_t     cx_q, cy_q;
  logic [1:0] kind_q;
  fade_ms_t   cft_q;

  // color state
  coord_t    present_x, present_y;
  coord_t    tracking_x, tracking_y;
  coord_t    target_x, target_y;
  fade_ms_t  remaining;
  cmd_kind_t cmd_state;
  logic      progress;
  logic      denied;

  // interpolation lanes
  coord_t dist_x, dist_y;
  logic   up_x, up_y;
  logic   busy_x, busy_y;
  coord_t step_x, step_y;
  prod_t  prod_x, prod_y;

  logic snap_now;
  logic at_target;

  always_ff @(posedge clk) begin
    if (rst) begin
      fade_on_write <= 1'b1;
      dflt_fade_ms  <= FADE_TIME_MIN;
      write_enable  <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FADE_ON_WRITE:     fade_on_write <= cfg_data[0];
        REG_DEFAULT_FADE_TIME: dflt_fade_ms  <= cfg_data;
        REG_WRITE_ENABLE:      write_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_q   <= op;
      ms_q   <= elapsed_ms;
      cx_q   <= color_x;
      cy_q   <= color_y;
      kind_q <= command_kind;
      cft_q  <= command_fade_time;
    end
  end

  assign at_target = (tracking_x == target_x) && (tracking_y == target_y);
  assign snap_now  = (TIME_BITS'(ms_q) >= remaining) || at_target;

  assign status.need_div = (op_q == OP_TICK) && (cmd_state == CMD_FADE) && !snap_now;
  assign status.div_busy = busy_x || busy_y;

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      up_x   <= target_x >= tracking_x;
      up_y   <= target_y >= tracking_y;
      dist_x <= (target_x >= tracking_x) ? target_x - tracking_x : tracking_x - target_x;
      dist_y <= (target_y >= tracking_y) ? target_y - tracking_y : tracking_y - target_y;
    end
  end

  assign prod_x = PROD_BITS'(ms_q) * PROD_BITS'(dist_x);
  assign prod_y = PROD_BITS'(ms_q) * PROD_BITS'(dist_y);

  xycf_div u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (prod_x),
    .divisor  (remaining),
    .busy     (busy_x),
    .quotient (step_x)
  );

  xycf_div u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (prod_y),
    .divisor  (remaining),
    .busy     (busy_y),
    .quotient (step_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      present_x  <= '0;
      present_y  <= '0;
      tracking_x <= '0;
      tracking_y <= '0;
      target_x   <= '1;
      target_y   <= '1;
      remaining  <= FADE_TIME_MIN;
      cmd_state  <= CMD_FADE;
      progress   <= 1'b0;
      denied     <= 1'b0;
    end else if (cmd.commit_interp) begin
      tracking_x <= up_x ? tracking_x + step_x : tracking_x - step_x;
      tracking_y <= up_y ? tracking_y + step_y : tracking_y - step_y;
      remaining  <= remaining - TIME_BITS'(ms_q);
      progress   <= 1'b1;
      denied     <= 1'b0;
    end else if (cmd.commit_simple) begin
      denied <= 1'b0;
      unique case (op_q)
        OP_TICK: begin
          unique case (cmd_state)
            CMD_NONE, CMD_STOP: progress <= 1'b0;
            CMD_FADE: begin
              // only reached here when snapping to the target
              tracking_x <= target_x;
              tracking_y <= target_y;
              progress   <= 1'b0;
              cmd_state  <= CMD_STOP;
              remaining  <= '0;
            end
            CMD_OTHER: ;
          endcase
        end
        OP_PRESENT: begin
          present_x <= cx_q;
          present_y <= cy_q;
          target_x  <= cx_q;
          target_y  <= cy_q;
          remaining <= fade_on_write ? dflt_fade_ms : '0;
          cmd_state <= CMD_FADE;
        end
        OP_COMMAND: begin
          if (write_enable) begin
            cmd_state <= cmd_kind_t'(kind_q);
            target_x  <= cx_q;
            target_y  <= cy_q;
            remaining <= cft_q;
          end else begin
            denied <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      res_tracking_x   <= tracking_x;
      res_tracking_y   <= tracking_y;
      res_present_x    <= present_x;
      res_present_y    <= present_y;
      res_fade_active  <= progress;
      res_write_denied <= denied;
    end
  end

endmodule

/* src/xycf_ctrl.sv */
// Sequencer for one item: latch, decide, multiply and divide when interpolating, report.
module xycf_ctrl import xycf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  output logic       result_valid,
  input  logic       result_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECIDE = 5'b00010,
    S_MUL    = 5'b00100,
    S_DIV    = 5'b01000,
    S_EMIT   = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   result_valid_next;
  logic   slot_free;

  assign item_ready = (state == S_IDLE);
  assign slot_free  = !result_valid || result_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (status.need_div) begin
          cmd.prep   = 1'b1;
          state_next = S_MUL;
        end else begin
          cmd.commit_simple = 1'b1;
          state_next        = S_EMIT;
        end
      end
      S_MUL: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (!status.div_busy) begin
          cmd.commit_interp = 1'b1;
          state_next        = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd.load_result = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    result_valid_next = result_valid;
    if (cmd.load_result) begin
      result_valid_next = 1'b1;
    end else if (result_ready) begin
      result_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

endmodule

/* src/xy_color_fade_engine.sv */
// x,y color fade engine: each item (timer tick, present-value write or color
// command write) yields exactly one result beat showing the tracking and present
// colors, the fade flag and a write-refused flag after the item. Writes and ticks
// that need no interpolation skip the multiply and divide states. A tick that
// moves the tracking color has its two coordinates divided in parallel by
// restoring dividers (elapsed * distance / remaining). Items are taken one at a
// time. A result beat that is not taken holds the engine only when the next
// result is ready to be written. A new item is accepted as soon as the previous
// result sits in the output register, even if that beat has not yet been taken.
// Config writes are taken at any time but should only be made while the block
// is idle.
module xy_color_fade_engine import xycf_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [REG_IDX_BITS-1:0] cfg_index,
  input  logic [TIME_BITS-1:0]    cfg_data,
  xycf_item_if.sink               item,
  xycf_result_if.source           result
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  xycf_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .status       (status),
    .cmd          (cmd)
  );

  xycf_datapath u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .cmd               (cmd),
    .status            (status),
    .op                (item.op),
    .elapsed_ms        (item.elapsed_ms),
    .color_x           (item.color_x),
    .color_y           (item.color_y),
    .command_kind      (item.command_kind),
    .command_fade_time (item.command_fade_time),
    .res_tracking_x    (result.tracking_x),
    .res_tracking_y    (result.tracking_y),
    .res_present_x     (result.present_x),
    .res_present_y     (result.present_y),
    .res_fade_active   (result.fade_active),
    .res_write_denied  (result.write_denied)
  );

endmodule

/* src/xycf_checker.sv */
// Port-level checks for the color fade engine, bound to the top level.
`include "xy_color_fade_engine_assert.svh"

module xycf_checker import xycf_pkg::*; (
  input logic   clk,
  input logic   rst,
  input logic   item_valid,
  input logic   item_ready,
  input logic   result_valid,
  input logic   result_ready,
  input coord_t tracking_x,
  input coord_t tracking_y,
  input coord_t present_x,
  input coord_t present_y,
  input logic   fade_active,
  input logic   write_denied
);

  // one item in flight: ready is low after an accept
  `XYCF_ASSERT_NEXT(a_one_in_flight, item_valid && item_ready, !item_ready)

  // a result beat carries known values
  `XYCF_ASSERT_IMP(a_result_known, result_valid,
    !$isunknown({tracking_x, tracking_y, present_x, present_y, fade_active, write_denied}))

  // stalled result beat holds
  `XYCF_ASSERT_NEXT(a_result_holds, result_valid && !result_ready,
    result_valid && $stable(tracking_x) && $stable(tracking_y) &&
    $stable(present_x) && $stable(present_y) && $stable(fade_active) &&
    $stable(write_denied))

  // reset leaves no beat pending
  `XYCF_ASSERT_RST(a_reset_empty, rst, !result_valid)

endmodule

bind xy_color_fade_engine xycf_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .tracking_x   (result.tracking_x),
  .tracking_y   (result.tracking_y),
  .present_x    (result.present_x),
  .present_y    (result.present_y),
  .fade_active  (result.fade_active),
  .write_denied (result.write_denied)
);
